[hdl/bbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_pkg: shared types and constants for the box bounce step
// Body record, configuration record, register indexes and helpers.
// ----------------------------------------------------------------------------
package bbb_pkg;

	localparam int V_W     = 32;          // velocity, position, spin
	localparam int E_W     = 31;          // energy
	localparam int M_W     = 31;          // mass
	localparam int T_W     = 16;          // time step
	localparam int R_W     = E_W + 17;    // 2E/m quotient
	localparam int SQ_W    = 64;          // sum of squares / sqrt radicand
	localparam int ROOT_W  = SQ_W / 2;
	localparam int IN_TDATA_W  = 304;
	localparam int OUT_TDATA_W = 160;
	localparam int CFG_IDX_W   = 3;
	localparam int AXIS_Y      = 1;

	localparam logic [V_W-1:0] VEL_MIN = 32'h8000_0000;
	localparam logic [V_W-1:0] VEL_MAX = 32'h7FFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X,
		REG_MIN_Y,
		REG_MIN_Z,
		REG_MAX_X,
		REG_MAX_Y,
		REG_MAX_Z,
		REG_FLOOR
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][V_W-1:0] pos;
		logic [2:0][V_W-1:0] vel;
		logic [V_W-1:0]      spin;
		logic [E_W-1:0]      energy;
		logic [M_W-1:0]      mass;
		logic [T_W-1:0]      dt;
		logic                hit;    // wall hit on the axis about to be handled
	} body_t;

	typedef struct packed {
		logic [2:0][V_W-1:0] lo;
		logic [2:0][V_W-1:0] hi;
		logic [15:0]         floor_e;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		lo:      {32'hFF9C_0000, 32'hFFEC_0000, 32'hFF9C_0000},
		hi:      {32'h0064_0000, 32'h00C8_0000, 32'h0064_0000},
		floor_e: 16'd66
	};

	function automatic logic [V_W-1:0] mag32(input logic [V_W-1:0] v);
		return v[V_W-1] ? (~v + 1'b1) : v;
	endfunction

	// p*2^16 + v*dt against the bounds at 32 fraction bits
	function automatic logic wall_hit(input logic [V_W-1:0] p, input logic signed [48:0] vdt,
			input logic [V_W-1:0] lo, input logic [V_W-1:0] hi);
		logic signed [49:0] pred;
		logic signed [49:0] lo_w;
		logic signed [49:0] hi_w;
		pred = $signed({{2{p[V_W-1]}}, p, 16'h0}) + $signed({vdt[48], vdt});
		lo_w = $signed({{2{lo[V_W-1]}}, lo, 16'h0});
		hi_w = $signed({{2{hi[V_W-1]}}, hi, 16'h0});
		return (pred < lo_w) || (pred > hi_w);
	endfunction

endpackage

[hdl/bbb_udiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_udiv: pipelined restoring divider
// One quotient bit per stage; needs dividend >> QW below the divisor.
// ----------------------------------------------------------------------------
module bbb_udiv #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [QW-1:0] quotient
);

	logic [DW-1:0] rem_s [1:QW-1];
	logic [QW-1:0] low_s [1:QW-1];
	logic [DW-1:0] dsr_s [1:QW-1];
	logic [QW-1:0] quo_s [1:QW];

	for (genvar g = 0; g < QW; g++) begin : g_step
		logic [DW-1:0] rem_p;
		logic [DW-1:0] dsr_p;
		logic [QW-1:0] low_p;
		logic [QW-1:0] quo_p;
		logic [DW:0]   trial;
		logic          take;

		if (g == 0) begin : g_in
			assign rem_p = DW'(dividend >> QW);
			assign low_p = dividend[QW-1:0];
			assign dsr_p = divisor;
			assign quo_p = '0;
		end else begin : g_mid
			assign rem_p = rem_s[g];
			assign low_p = low_s[g];
			assign dsr_p = dsr_s[g];
			assign quo_p = quo_s[g];
		end

		assign trial = {rem_p, low_p[QW-1]};
		assign take  = trial >= {1'b0, dsr_p};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[g+1] <= {quo_p[QW-2:0], take};
			end
		end

		if (g < QW - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1] <= take ? DW'(trial - {1'b0, dsr_p}) : trial[DW-1:0];
					low_s[g+1] <= {low_p[QW-2:0], 1'b0};
					dsr_s[g+1] <= dsr_p;
				end
			end
		end
	end

	assign quotient = quo_s[QW];

endmodule

[hdl/bbb_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_isqrt: pipelined integer square root
// Digit-by-digit floor sqrt, one root bit per stage.
// ----------------------------------------------------------------------------
module bbb_isqrt #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   radicand,
	output logic [W/2-1:0] root
);

	localparam int N = W / 2;

	logic [W-1:0] x_s [1:N-1];
	logic [W-1:0] r_s [1:N];

	for (genvar g = 0; g < N; g++) begin : g_step
		localparam logic [W-1:0] BITV = W'(1) << (2 * (N - 1 - g));
		logic [W-1:0] x_p;
		logic [W-1:0] r_p;
		logic [W-1:0] trial;
		logic         take;

		if (g == 0) begin : g_in
			assign x_p = radicand;
			assign r_p = '0;
		end else begin : g_mid
			assign x_p = x_s[g];
			assign r_p = r_s[g];
		end

		assign trial = r_p + BITV;
		assign take  = x_p >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[g+1] <= take ? ((r_p >> 1) + BITV) : (r_p >> 1);
			end
		end

		if (g < N - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[g+1] <= take ? (x_p - trial) : x_p;
				end
			end
		end
	end

	assign root = r_s[N][N-1:0];

endmodule

[hdl/bbb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_front: input stage
// Takes bodies off the slave stream and tests the x wall.
// ----------------------------------------------------------------------------
module bbb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bbb_pkg::cfg_t                   cfg,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bbb_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            q_full,
	output logic                            push,
	output bbb_pkg::body_t                  push_body
);
	import bbb_pkg::*;

	logic              en;
	logic              v_s1, v_s2;
	body_t             body_s1, body_s2, body_c, body_h;
	logic signed [48:0] vdt_s1;

	assign en       = !v_s2 || !q_full;
	assign s_tready = en;
	assign push     = v_s2 && !q_full;
	assign push_body = body_s2;

	always_comb begin
		body_c.pos[0] = s_tdata[31:0];
		body_c.pos[1] = s_tdata[63:32];
		body_c.pos[2] = s_tdata[95:64];
		body_c.vel[0] = s_tdata[127:96];
		body_c.vel[1] = s_tdata[159:128];
		body_c.vel[2] = s_tdata[191:160];
		body_c.spin   = s_tdata[223:192];
		body_c.energy = s_tdata[254:224];
		body_c.mass   = s_tdata[285:255];
		body_c.dt     = s_tdata[301:286];
		body_c.hit    = 1'b0;
	end

	// x wall test on the stage 1 body
	always_comb begin
		body_h     = body_s1;
		body_h.hit = wall_hit(body_s1.pos[0], vdt_s1, cfg.lo[0], cfg.hi[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			body_s1 <= body_c;
			vdt_s1  <= $signed(body_c.vel[0]) * $signed({1'b0, body_c.dt});
			body_s2 <= body_h;
		end
	end

endmodule

[hdl/bbb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_queue: body queue between front and back
// Small register FIFO; lets the two sides stall independently.
// ----------------------------------------------------------------------------
module bbb_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bbb_pkg::body_t push_body,
	output logic           full,
	input  logic           pop,
	output bbb_pkg::body_t pop_body,
	output logic           empty
);
	import bbb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	body_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_body = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_body;
		end
	end

endmodule

[hdl/bbb_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_axis: bounce and rescale for one axis
// Applies the wall response, rescales the velocity to sqrt(2E/m) and tests
// the wall of the next axis.
// ----------------------------------------------------------------------------
module bbb_axis #(
	parameter int AXIS = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  bbb_pkg::cfg_t  cfg,
	input  logic           in_valid,
	input  bbb_pkg::body_t in_body,
	output logic           out_valid,
	output bbb_pkg::body_t out_body
);
	import bbb_pkg::*;

	localparam int LAT_SQ = ROOT_W;
	localparam int LAT_S  = R_W + LAT_SQ;       // speed: divide then sqrt
	localparam int DLY_N  = LAT_S - 2 - LAT_SQ; // align norm with speed
	localparam int LAT_Q  = V_W;

	// bounce response
	body_t          b1_c;
	logic [E_W-1:0] e_h;
	logic [V_W-1:0] spin_t, vneg;
	logic           stop;

	always_comb begin
		b1_c   = in_body;
		e_h    = in_body.energy >> 1;
		spin_t = in_body.spin + {{(V_W-1){1'b0}}, in_body.spin[V_W-1]};
		vneg   = (in_body.vel[AXIS] == VEL_MIN) ? VEL_MAX : (~in_body.vel[AXIS] + 1'b1);
		stop   = (AXIS == AXIS_Y) && (e_h < {{(E_W-16){1'b0}}, cfg.floor_e});
		if (in_body.hit) begin
			b1_c.spin      = {spin_t[V_W-1], spin_t[V_W-1:1]};
			b1_c.energy    = e_h;
			b1_c.vel[AXIS] = vneg;
			if (stop) begin
				b1_c.vel = '0;
			end
		end
		if (in_body.mass == '0) begin
			b1_c.mass = M_W'(1);
		end
	end

	logic                 v_s1;
	body_t                b_s1;
	logic [2:0][SQ_W-1:0] sqp_s2;
	logic [SQ_W-1:0]      sq_s3;
	logic [ROOT_W-1:0]    n_raw;
	logic [ROOT_W-1:0]    n_d [1:DLY_N];
	logic [R_W-1:0]       r_div;
	logic [ROOT_W-1:0]    s_root;
	logic                 vd [1:LAT_S];
	body_t                b_d [1:LAT_S];
	logic [2:0][V_W-1:0]  mag_c;
	logic                 v_p;
	body_t                b_p;
	logic [ROOT_W-1:0]    n_p;
	logic [2:0][SQ_W-1:0] prod_p;
	logic [2:0][V_W-1:0]  q_c;
	logic                 vq [1:LAT_Q];
	body_t                b_q [1:LAT_Q];
	logic                 v_o;
	body_t                b_o, o_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = mag32(b_d[LAT_S].vel[i]);
		end
	end

	// rescaled components on a hit, saturated, with sign of the input component
	always_comb begin
		o_c = b_q[LAT_Q];
		if (b_q[LAT_Q].hit) begin
			for (int i = 0; i < 3; i++) begin
				if (b_q[LAT_Q].vel == '0) begin
					o_c.vel[i] = '0;
				end else if (b_q[LAT_Q].vel[i][V_W-1]) begin
					o_c.vel[i] = (q_c[i] > VEL_MIN) ? VEL_MIN : (~q_c[i] + 1'b1);
				end else begin
					o_c.vel[i] = q_c[i][V_W-1] ? VEL_MAX : q_c[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_p  <= 1'b0;
			v_o  <= 1'b0;
			for (int k = 1; k <= LAT_S; k++) begin
				vd[k] <= 1'b0;
			end
			for (int k = 1; k <= LAT_Q; k++) begin
				vq[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1  <= in_valid;
			vd[1] <= v_s1;
			for (int k = 2; k <= LAT_S; k++) begin
				vd[k] <= vd[k-1];
			end
			v_p   <= vd[LAT_S];
			vq[1] <= v_p;
			for (int k = 2; k <= LAT_Q; k++) begin
				vq[k] <= vq[k-1];
			end
			v_o <= vq[LAT_Q];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1 <= b1_c;
			for (int i = 0; i < 3; i++) begin
				sqp_s2[i] <= mag32(b_s1.vel[i]) * mag32(b_s1.vel[i]);
			end
			sq_s3  <= sqp_s2[0] + sqp_s2[1] + sqp_s2[2];
			n_d[1] <= n_raw;
			for (int k = 2; k <= DLY_N; k++) begin
				n_d[k] <= n_d[k-1];
			end
			b_d[1] <= b_s1;
			for (int k = 2; k <= LAT_S; k++) begin
				b_d[k] <= b_d[k-1];
			end
			b_p <= b_d[LAT_S];
			n_p <= n_d[DLY_N];
			for (int i = 0; i < 3; i++) begin
				prod_p[i] <= mag_c[i] * s_root;
			end
			b_q[1] <= b_p;
			for (int k = 2; k <= LAT_Q; k++) begin
				b_q[k] <= b_q[k-1];
			end
			b_o <= o_c;
		end
	end

	bbb_isqrt #(.W(SQ_W)) u_norm (
		.clk      (clk),
		.en       (en),
		.radicand (sq_s3),
		.root     (n_raw)
	);

	bbb_udiv #(.NW(R_W), .DW(M_W), .QW(R_W)) u_ratio (
		.clk      (clk),
		.en       (en),
		.dividend ({b_s1.energy, 17'h0}),
		.divisor  (b_s1.mass),
		.quotient (r_div)
	);

	bbb_isqrt #(.W(SQ_W)) u_speed (
		.clk      (clk),
		.en       (en),
		.radicand ({r_div, 16'h0}),
		.root     (s_root)
	);

	for (genvar i = 0; i < 3; i++) begin : g_comp
		bbb_udiv #(.NW(SQ_W), .DW(ROOT_W), .QW(V_W)) u_scale (
			.clk      (clk),
			.en       (en),
			.dividend (prod_p[i]),
			.divisor  (n_p),
			.quotient (q_c[i])
		);
	end

	if (AXIS < 2) begin : g_next
		localparam int NX = AXIS + 1;
		logic               v_h1, v_h2;
		body_t              b_h1, b_h2, b_hc;
		logic signed [48:0] vdt_h1;

		// next wall test on the stage 1 body
		always_comb begin
			b_hc     = b_h1;
			b_hc.hit = wall_hit(b_h1.pos[NX], vdt_h1, cfg.lo[NX], cfg.hi[NX]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_h1 <= 1'b0;
				v_h2 <= 1'b0;
			end else if (en) begin
				v_h1 <= v_o;
				v_h2 <= v_h1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				b_h1   <= b_o;
				vdt_h1 <= $signed(b_o.vel[NX]) * $signed({1'b0, b_o.dt});
				b_h2   <= b_hc;
			end
		end

		assign out_valid = v_h2;
		assign out_body  = b_h2;
	end else begin : g_last
		always_comb begin
			out_body     = b_o;
			out_body.hit = 1'b0;
		end
		assign out_valid = v_o;
	end

endmodule

[hdl/box_boundary_bounce_step_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_boundary_bounce_step_top: box wall bounce with energy loss
// Front stage, body queue and three pipelined axis units.
// ----------------------------------------------------------------------------
// Usage
//   Bodies arrive on the s_ stream, one per transaction; the updated
//   velocity, spin and energy leave on the m_ stream in the same order,
//   one result transaction per body.
//   Configuration (box corners, energy floor) is written on cfg_we /
//   cfg_index / cfg_data, one register per cycle, while the block is idle.
//   Path: a body meets 352 register stages with an empty queue and an idle
//   output: 2 in the front, 1 in the queue, 117 in each of the x and y
//   units (115 plus 2 for the next wall test) and 115 in z. Each axis
//   unit is dominated by the 48-step divide and 32-step square root for
//   sqrt(2E/m). Throughput: one body per cycle when not stalled; every
//   divide and root is fully pipelined.
//   Reset: clears all valid flags and the queue, and loads the default box
//   and energy floor.
//   Stall: when m_tready is low with a result waiting, the whole back end
//   freezes; the queue keeps taking bodies until it is full with a body
//   waiting in the second front stage, then s_tready drops.
// ----------------------------------------------------------------------------
module box_boundary_bounce_step_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [bbb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data,
	// body input
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pos_x, pos_y, pos_z, vel_in_x, vel_in_y, vel_in_z, spin_in,
	// energy_in (31), mass (31), time_step (16), 2 bits zero pad
	input  logic [bbb_pkg::IN_TDATA_W-1:0]   s_tdata,
	// result output
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// vel_out_x, vel_out_y, vel_out_z, spin_out, energy_out (31), 1 bit pad
	output logic [bbb_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import bbb_pkg::*;

	cfg_t  cfg_q;
	logic  en_b;
	logic  q_push, q_full, q_pop, q_empty;
	body_t q_in_body, q_out_body;
	logic  x_valid, y_valid, z_valid;
	body_t x_body, y_body, z_body;

	// register file; unknown indexes fall through the default arm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_X: cfg_q.lo[0]   <= cfg_data;
				REG_MIN_Y: cfg_q.lo[1]   <= cfg_data;
				REG_MIN_Z: cfg_q.lo[2]   <= cfg_data;
				REG_MAX_X: cfg_q.hi[0]   <= cfg_data;
				REG_MAX_Y: cfg_q.hi[1]   <= cfg_data;
				REG_MAX_Z: cfg_q.hi[2]   <= cfg_data;
				REG_FLOOR: cfg_q.floor_e <= cfg_data[15:0];
				default:   cfg_q         <= cfg_q;
			endcase
		end
	end

	// back end moves whenever the output register is free or being taken
	assign en_b  = !m_tvalid || m_tready;
	assign q_pop = en_b && !q_empty;

	bbb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (q_push),
		.push_body (q_in_body)
	);

	bbb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_body (q_in_body),
		.full      (q_full),
		.pop       (q_pop),
		.pop_body  (q_out_body),
		.empty     (q_empty)
	);

	bbb_axis #(.AXIS(0)) u_axis_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.cfg       (cfg_q),
		.in_valid  (q_pop),
		.in_body   (q_out_body),
		.out_valid (x_valid),
		.out_body  (x_body)
	);

	bbb_axis #(.AXIS(1)) u_axis_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.cfg       (cfg_q),
		.in_valid  (x_valid),
		.in_body   (x_body),
		.out_valid (y_valid),
		.out_body  (y_body)
	);

	// z unit ends in the output register
	bbb_axis #(.AXIS(2)) u_axis_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.cfg       (cfg_q),
		.in_valid  (y_valid),
		.in_body   (y_body),
		.out_valid (z_valid),
		.out_body  (z_body)
	);

	assign m_tvalid = z_valid;
	assign m_tdata  = {1'b0, z_body.energy, z_body.spin,
		z_body.vel[2], z_body.vel[1], z_body.vel[0]};

endmodule

[hdl/bbb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_checker: port-level checks for the box bounce step
// Output hold under stall, pad bit, input ready and reset behaviour.
// ----------------------------------------------------------------------------
module bbb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [bbb_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// energy is 31 bits; the top bit of the result is pad
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[bbb_pkg::OUT_TDATA_W-1] == 1'b0))
		else $error("result pad bit set");

	a_in_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(s_tready))
		else $error("input ready unknown");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid straight after reset");

endmodule

bind box_boundary_bounce_step_top bbb_checker u_chk (.*);

[dv/bounce_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounce_checker: result predictor and scoreboard for the box bounce step
// Watches the configuration port and both streams, predicts each body's
// bounce and compares the result transactions in order.
// ----------------------------------------------------------------------------
module bounce_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bbb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [bbb_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [bbb_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                              fail_count,
	output int                              pending
);
	import bbb_pkg::*;

	typedef struct packed {
		logic [31:0] vx, vy, vz, spin;
		logic [30:0] energy;
	} bounce_res_t;

	bounce_res_t expected_bounces[$];

	longint      wall_lo[3], wall_hi[3];
	logic [15:0] stop_floor;

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] abs64(input longint a);
		return a < 0 ? -a : a;
	endfunction

	// velocity to its direction times sqrt(2E/m)
	function automatic void retarget_speed(ref longint v[3], input logic [63:0] e,
			input logic [63:0] m);
		logic [63:0] sq, n, s, q;
		sq = 0;
		for (int i = 0; i < 3; i++) sq += abs64(v[i]) * abs64(v[i]);
		if (sq == 0) begin
			v[0] = 0; v[1] = 0; v[2] = 0;
			return;
		end
		n = root64(sq);
		if (m == 0) m = 1;
		s = root64(((e << 17) / m) << 16);
		for (int i = 0; i < 3; i++) begin
			q = abs64(v[i]) * s / n;
			if (v[i] < 0) v[i] = (q > 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(q);
			else          v[i] = (q > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(q);
		end
	endfunction

	function automatic bounce_res_t predict_bounce(input logic [IN_TDATA_W-1:0] d);
		longint      p[3], v[3], spin, pred;
		logic [63:0] e, m, dt;
		bounce_res_t r;
		for (int a = 0; a < 3; a++) begin
			p[a] = longint'($signed(d[32*a +: 32]));
			v[a] = longint'($signed(d[96 + 32*a +: 32]));
		end
		spin = longint'($signed(d[223:192]));
		e    = d[254:224];
		m    = d[285:255];
		dt   = d[301:286];
		for (int a = 0; a < 3; a++) begin
			pred = p[a] * 65536 + v[a] * longint'(dt);
			if (!(pred < wall_lo[a] * 65536 || pred > wall_hi[a] * 65536)) continue;
			spin = spin / 2;
			e >>= 1;
			v[a] = (v[a] == -longint'(64'h8000_0000)) ? longint'(64'h7FFF_FFFF) : -v[a];
			// stopping bounce on the floor axis
			if (a == AXIS_Y && e < stop_floor) begin
				v[0] = 0; v[1] = 0; v[2] = 0;
			end
			retarget_speed(v, e, m);
		end
		r.vx = v[0][31:0];
		r.vy = v[1][31:0];
		r.vz = v[2][31:0];
		r.spin = spin[31:0];
		r.energy = e[30:0];
		return r;
	endfunction

	assign pending = expected_bounces.size();

	always @(posedge clk or negedge arst_n) begin
		bounce_res_t exp_r, got;
		if (!arst_n) begin
			wall_lo[0] <= -6553600; wall_lo[1] <= -1310720; wall_lo[2] <= -6553600;
			wall_hi[0] <= 6553600;  wall_hi[1] <= 13107200; wall_hi[2] <= 6553600;
			stop_floor <= 16'd66;
			fail_count <= 0;
			expected_bounces.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_X: wall_lo[0] <= longint'($signed(cfg_data));
					REG_MIN_Y: wall_lo[1] <= longint'($signed(cfg_data));
					REG_MIN_Z: wall_lo[2] <= longint'($signed(cfg_data));
					REG_MAX_X: wall_hi[0] <= longint'($signed(cfg_data));
					REG_MAX_Y: wall_hi[1] <= longint'($signed(cfg_data));
					REG_MAX_Z: wall_hi[2] <= longint'($signed(cfg_data));
					REG_FLOOR: stop_floor <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) expected_bounces.push_back(predict_bounce(s_tdata));
			if (m_tvalid && m_tready) begin
				got.vx = m_tdata[31:0];
				got.vy = m_tdata[63:32];
				got.vz = m_tdata[95:64];
				got.spin = m_tdata[127:96];
				got.energy = m_tdata[158:128];
				if (expected_bounces.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_bounces.pop_front();
					if (got != exp_r) fail_count <= fail_count + 1;
					if (got.vx != exp_r.vx)
						$error("vel_out_x: expected %h, got %h", exp_r.vx, got.vx);
					if (got.vy != exp_r.vy)
						$error("vel_out_y: expected %h, got %h", exp_r.vy, got.vy);
					if (got.vz != exp_r.vz)
						$error("vel_out_z: expected %h, got %h", exp_r.vz, got.vz);
					if (got.spin != exp_r.spin)
						$error("spin_out: expected %h, got %h", exp_r.spin, got.spin);
					if (got.energy != exp_r.energy)
						$error("energy_out: expected %h, got %h", exp_r.energy, got.energy);
				end
			end
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the box bounce step
// Directed and random bodies over several box settings, with random idling
// on both streams and one long output hold-off; checking in bounce_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import bbb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] SPARE_IDX = 3'd7;  // beyond the register list
	localparam logic [31:0] UNIT = 32'h0001_0000;       // 1.0 in Q16.16
	localparam int DRAIN_CYCLES = 400;                   // longer than the block's pipeline

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [31:0]            cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	// pos_x, pos_y, pos_z, vel_in_x, vel_in_y, vel_in_z, spin_in, energy_in,
	// mass, time_step, pad
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// vel_out_x, vel_out_y, vel_out_z, spin_out, energy_out, pad
	logic [OUT_TDATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req;      // cycles of output hold-off requested by the stimulus
	int hold_left;
	logic hold_used;

	box_boundary_bounce_step_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	bounce_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// receiver: random back-pressure, plus a long hold-off counted here so the
	// queue fills and s_tready drops while the sender keeps offering
	initial begin
		m_tready = 0;
		hold_left = 0;
		hold_used = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0 && !hold_used) begin
				hold_left = hold_req;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// one body transaction; valid stays up between back-to-back bodies
	task automatic send_body(input logic [31:0] px, py, pz, vx, vy, vz, spin,
			input logic [30:0] e, m, input logic [15:0] dt);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, dt, m, e, spin, vz, vy, vx, pz, py, px};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// let every result drain, then the block's latency, before touching registers
	task automatic settle();
		end_burst();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz,
			input logic [15:0] fl);
		write_reg(REG_MIN_X, lx);
		write_reg(REG_MIN_Y, ly);
		write_reg(REG_MIN_Z, lz);
		write_reg(REG_MAX_X, hx);
		write_reg(REG_MAX_Y, hy);
		write_reg(REG_MAX_Z, hz);
		write_reg(REG_FLOOR, {16'h0, fl});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] near_box();
		return $urandom_range(300 * 65536) - 150 * 65536;
	endfunction

	function automatic logic [31:0] modest_vel();
		return $urandom_range(400 * 65536) - 200 * 65536;
	endfunction

	// mostly plausible bodies near the walls, the rest raw noise
	task automatic random_bodies(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 70)
				send_body(near_box(), near_box(), near_box(),
					modest_vel(), modest_vel(), modest_vel(), $urandom(),
					31'($urandom_range(1 << 24)), 31'($urandom_range(1 << 20, 1 << 12)),
					16'($urandom_range(16'hFFFF)));
			else
				send_body($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), 31'($urandom()), 31'($urandom()),
					16'($urandom()));
		end
	endtask

	initial begin
		arst_n      = 0;
		cfg_we      = 0;
		cfg_index   = '0;
		cfg_data    = '0;
		s_tvalid    = 0;
		s_tdata     = '0;
		tx_idle_pct = 28;
		rx_idle_pct = 71;
		hold_req    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed bodies against the reset box
		send_body(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_body(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 16'hFFFF);
		send_body(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
		send_body(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN,
			31'h7FFF_FFFF, 31'h1, 16'hFFFF);
		// zero mass on a hit
		send_body(32'h0070_0000, 0, 0, UNIT, UNIT, 0, UNIT, 31'h0001_0000, 0, 16'h8000);
		// stopping bounce below the floor
		send_body(0, 32'hFFEB_0000, 0, UNIT, 32'hFFFF_0000, UNIT, 32'hFFFF_FFFD,
			31'd100, UNIT[30:0], 16'h1000);
		// y hit just above the floor keeps moving
		send_body(0, 32'hFFEB_0000, 0, UNIT, 32'hFFFF_0000, UNIT, 32'h5,
			31'd140, UNIT[30:0], 16'h1000);
		// zero vector outside the box
		send_body(32'h0080_0000, 32'h0100_0000, 32'hFF00_0000, 0, 0, 0, UNIT,
			31'h0010_0000, UNIT[30:0], 16'hFFFF);
		// exactly on the bounds counts as inside
		send_body(32'h0064_0000, 32'hFFEC_0000, 32'hFF9C_0000, 0, 0, 0, UNIT,
			31'h0010_0000, UNIT[30:0], 16'h0);
		send_body(32'hFF9C_0000, 32'h00C8_0000, 32'h0064_0000, 0, 0, 0, UNIT,
			31'h0010_0000, UNIT[30:0], 16'hFFFF);
		// one LSB beyond the bound through the velocity term
		send_body(32'h0064_0000, 0, 0, 32'h1, 0, 0, UNIT, 31'h0010_0000,
			UNIT[30:0], 16'h1);
		// all three axes hit, most negative velocity negated
		send_body(32'h0070_0000, 32'h00D0_0000, 32'hFF90_0000, VEL_MIN, 32'h0100_0000,
			VEL_MIN, 32'h8000_0001, 31'h7FFF_FFFF, 31'h1, 16'hFFFF);
		random_bodies(150);
		// long output hold-off while bodies keep coming
		hold_req = 600;
		random_bodies(40);
		settle();

		// widest box, highest floor
		tx_idle_pct = 71;
		rx_idle_pct = 28;
		set_box(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MAX, VEL_MAX, VEL_MAX, 16'hFFFF);
		random_bodies(120);
		settle();

		// inverted box: every axis bounces, zero floor
		set_box(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MIN, VEL_MIN, VEL_MIN, 16'h0);
		random_bodies(150);
		settle();

		// random corners, no idling
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_box(near_box(), near_box(), near_box(), near_box(), near_box(), near_box(),
			16'($urandom_range(16'hFFFF)));
		random_bodies(180);
		settle();

		// back to the reset box; the spare index must be ignored
		write_reg(SPARE_IDX, 32'h0000_0001);
		set_box(CFG_RESET.lo[0], CFG_RESET.lo[1], CFG_RESET.lo[2],
			CFG_RESET.hi[0], CFG_RESET.hi[1], CFG_RESET.hi[2], CFG_RESET.floor_e);
		random_bodies(150);
		settle();

		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
hdl/bbb_pkg.sv
hdl/bbb_udiv.sv
hdl/bbb_isqrt.sv
hdl/bbb_front.sv
hdl/bbb_queue.sv
hdl/bbb_axis.sv
hdl/box_boundary_bounce_step_top.sv
hdl/bbb_checker.sv
dv/bounce_checker.sv
dv/tb_top.sv
